FILE: hdl/assert_macros.svh
// Assertion helpers shared by the ray/sphere pipeline
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define RSI_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rsi assertion failed");

// next-cycle implication
`define RSI_ASSERT_NXT(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("rsi assertion failed");

`endif

FILE: hdl/rsi_pkg.sv
// ----------------------------------------------------------------------------
// rsi_pkg
// Shared widths, register codes and the tag that rides the sqrt pipeline.
// ----------------------------------------------------------------------------
package rsi_pkg;

   localparam int B_W    = 37;   // b in Q21.16, signed
   localparam int DISC_W = 76;   // discriminant in Q.32
   localparam int ROOT_W = 38;   // floor sqrt of discriminant

   localparam logic [1:0] REG_CENTER_X = 2'd0;
   localparam logic [1:0] REG_CENTER_Y = 2'd1;
   localparam logic [1:0] REG_CENTER_Z = 2'd2;
   localparam logic [1:0] REG_RADIUS   = 2'd3;

   typedef struct packed {
      logic                  valid;
      logic                  miss;
      logic signed [B_W-1:0] b16;
   } rsi_tag_type;

endpackage

FILE: hdl/ray_sphere_intersect.sv
// An accepted start passes the front stages, the square root and the output register to rsp_valid.
// Throughput: one ray per cycle; busy is always low, rays stream back to back.
// Depth is set by the 38-stage square root (one root bit per stage) plus
// six front stages and one output register. Results cannot be stalled.
// Synchronous active-high reset clears all valid bits and loads the
// registers to centre 0 and radius 1.0.
// ----------------------------------------------------------------------------
// ray_sphere_intersect
// Ray versus configured sphere, nearer-root hit distance in Q16.16 when positive.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ray_sphere_intersect
   import rsi_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   // ray transfer
   input  logic               start,
   output logic               busy,
   input  logic signed [31:0] req_origin_x,
   input  logic signed [31:0] req_origin_y,
   input  logic signed [31:0] req_origin_z,
   input  logic signed [15:0] req_dir_x,
   input  logic signed [15:0] req_dir_y,
   input  logic signed [15:0] req_dir_z,
   // result transfer
   output logic               rsp_valid,
   output logic               rsp_hit,
   output logic [31:0]        rsp_distance,
   // register port
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [3:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   logic signed [31:0] center_x, center_y, center_z;
   logic [30:0]        radius;
   rsi_tag_type        front_tag, sqrt_tag;
   logic [DISC_W-1:0]  disc;
   logic [ROOT_W-1:0]  root;

   // final stage
   logic signed [39:0] near_dist;
   logic               hit_in;
   logic [31:0]        distance_in;
   logic               rsp_valid_ff, rsp_hit_ff;
   logic [31:0]        rsp_distance_ff;

   // every cycle takes a new ray
   assign busy = 1'b0;

   rsi_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready),
      .center_x (center_x),
      .center_y (center_y),
      .center_z (center_z),
      .radius   (radius)
   );

   // offset, dot product, norms, discriminant
   rsi_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (start && !busy),
      .origin_x (req_origin_x),
      .origin_y (req_origin_y),
      .origin_z (req_origin_z),
      .dir_x    (req_dir_x),
      .dir_y    (req_dir_y),
      .dir_z    (req_dir_z),
      .center_x (center_x),
      .center_y (center_y),
      .center_z (center_z),
      .radius   (radius),
      .tag      (front_tag),
      .disc     (disc)
   );

   rsi_sqrt u_sqrt (
      .clock   (clock),
      .reset   (reset),
      .tag_in  (front_tag),
      .disc    (disc),
      .tag_out (sqrt_tag),
      .root    (root)
   );

   // nearer root: -b - sqrt(disc); zero or negative is a miss
   assign near_dist   = 40'sd0 - 40'(sqrt_tag.b16) - 40'(root);
   assign hit_in      = !sqrt_tag.miss && (near_dist > 40'sd0);
   assign distance_in = !hit_in ? 32'd0 :
                        (near_dist[39:32] != 8'd0) ? 32'hFFFF_FFFF : near_dist[31:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= sqrt_tag.valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_hit_ff      <= hit_in;
      rsp_distance_ff <= distance_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_hit      = rsp_hit_ff;
   assign rsp_distance = rsp_distance_ff;

   // miss carries a zero distance, a hit a positive one
   `RSI_ASSERT_IMP(a_miss_zero, clock, reset, rsp_valid && !rsp_hit, rsp_distance == 32'd0)
   `RSI_ASSERT_IMP(a_hit_pos, clock, reset, rsp_valid && rsp_hit, rsp_distance != 32'd0)
   // nothing comes out right after reset
   `RSI_ASSERT_NXT(a_reset_quiet, clock, reset, !rsp_valid)

endmodule

FILE: hdl/rsi_csr.sv
// ----------------------------------------------------------------------------
// rsi_csr
// APB register file: sphere centre and radius.
// ----------------------------------------------------------------------------
module rsi_csr
   import rsi_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready,
   output logic signed [31:0] center_x,
   output logic signed [31:0] center_y,
   output logic signed [31:0] center_z,
   output logic [30:0] radius
);

   logic signed [31:0] center_x_ff, center_y_ff, center_z_ff;
   logic [30:0]        radius_ff;
   logic               wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff <= '0;
         center_y_ff <= '0;
         center_z_ff <= '0;
         radius_ff   <= 31'd65536;
      end else if (wr_en) begin
         unique case (paddr[3:2])
            REG_CENTER_X: center_x_ff <= pwdata;
            REG_CENTER_Y: center_y_ff <= pwdata;
            REG_CENTER_Z: center_z_ff <= pwdata;
            REG_RADIUS:   radius_ff   <= pwdata[30:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         REG_CENTER_X: prdata = center_x_ff;
         REG_CENTER_Y: prdata = center_y_ff;
         REG_CENTER_Z: prdata = center_z_ff;
         REG_RADIUS:   prdata = {1'b0, radius_ff};
         default:      prdata = '0;
      endcase
   end

   assign center_x = center_x_ff;
   assign center_y = center_y_ff;
   assign center_z = center_z_ff;
   assign radius   = radius_ff;

endmodule

FILE: hdl/rsi_front.sv
// ----------------------------------------------------------------------------
// rsi_front
// Six stages: offset, products, sums, b squared partials, lhs, discriminant.
// ----------------------------------------------------------------------------
module rsi_front
   import rsi_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  logic signed [31:0] origin_x,
   input  logic signed [31:0] origin_y,
   input  logic signed [31:0] origin_z,
   input  logic signed [15:0] dir_x,
   input  logic signed [15:0] dir_y,
   input  logic signed [15:0] dir_z,
   input  logic signed [31:0] center_x,
   input  logic signed [31:0] center_y,
   input  logic signed [31:0] center_z,
   input  logic [30:0]        radius,
   output rsi_tag_type        tag,
   output logic [DISC_W-1:0]  disc
);

   // stage 1: offset
   logic               v1_ff;
   logic signed [32:0] ox1_ff, oy1_ff, oz1_ff;
   logic signed [15:0] dx1_ff, dy1_ff, dz1_ff;
   // stage 2: products
   logic               v2_ff;
   logic signed [48:0] pdx2_ff, pdy2_ff, pdz2_ff;
   logic signed [48:0] pdx2_in, pdy2_in, pdz2_in;
   logic [65:0]        sqx2_ff, sqy2_ff, sqz2_ff;
   logic [65:0]        sqx2_in, sqy2_in, sqz2_in;
   logic [61:0]        r2_2_ff;
   // stage 3: sums
   logic               v3_ff;
   logic signed [50:0] b30;
   logic signed [B_W-1:0] b3_ff;
   logic [67:0]        nrm3_ff;
   logic [61:0]        r2_3_ff;
   // stage 4: b squared partials
   logic               v4_ff;
   logic [B_W-1:0]     bmag;
   logic [37:0]        hh4_ff;
   logic [36:0]        hl4_ff;
   logic [35:0]        ll4_ff;
   logic signed [B_W-1:0] b4_ff;
   logic [67:0]        nrm4_ff;
   logic [61:0]        r2_4_ff;
   // stage 5: lhs
   logic               v5_ff;
   logic [DISC_W-1:0]  lhs5_ff;
   logic signed [B_W-1:0] b5_ff;
   logic [67:0]        nrm5_ff;
   // stage 6: discriminant
   logic               v6_ff;
   logic               miss6_ff;
   logic signed [B_W-1:0] b6_ff;
   logic [DISC_W-1:0]  disc6_ff;

   assign pdx2_in = ox1_ff * dx1_ff;
   assign pdy2_in = oy1_ff * dy1_ff;
   assign pdz2_in = oz1_ff * dz1_ff;
   assign sqx2_in = ox1_ff * ox1_ff;
   assign sqy2_in = oy1_ff * oy1_ff;
   assign sqz2_in = oz1_ff * oz1_ff;
   assign b30     = 51'(pdx2_ff) + 51'(pdy2_ff) + 51'(pdz2_ff);
   assign bmag    = b3_ff[B_W-1] ? B_W'(-b3_ff) : B_W'(b3_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      ox1_ff  <= 33'(origin_x) - 33'(center_x);
      oy1_ff  <= 33'(origin_y) - 33'(center_y);
      oz1_ff  <= 33'(origin_z) - 33'(center_z);
      dx1_ff  <= dir_x;
      dy1_ff  <= dir_y;
      dz1_ff  <= dir_z;

      pdx2_ff <= pdx2_in;
      pdy2_ff <= pdy2_in;
      pdz2_ff <= pdz2_in;
      sqx2_ff <= sqx2_in;
      sqy2_ff <= sqy2_in;
      sqz2_ff <= sqz2_in;
      r2_2_ff <= radius * radius;

      b3_ff   <= b30[50:14];   // floor toward minus infinity
      nrm3_ff <= 68'(sqx2_ff) + 68'(sqy2_ff) + 68'(sqz2_ff);
      r2_3_ff <= r2_2_ff;

      hh4_ff  <= bmag[36:18] * bmag[36:18];
      hl4_ff  <= bmag[36:18] * bmag[17:0];
      ll4_ff  <= bmag[17:0] * bmag[17:0];
      b4_ff   <= b3_ff;
      nrm4_ff <= nrm3_ff;
      r2_4_ff <= r2_3_ff;

      lhs5_ff <= (DISC_W'(hh4_ff) << 36) + (DISC_W'(hl4_ff) << 19)
               + DISC_W'(ll4_ff) + DISC_W'(r2_4_ff);
      b5_ff   <= b4_ff;
      nrm5_ff <= nrm4_ff;

      miss6_ff <= DISC_W'(nrm5_ff) > lhs5_ff;
      b6_ff    <= b5_ff;
      disc6_ff <= lhs5_ff - DISC_W'(nrm5_ff);
   end

   assign tag  = {v6_ff, miss6_ff, b6_ff};
   assign disc = disc6_ff;

endmodule

FILE: hdl/rsi_sqrt.sv
// ----------------------------------------------------------------------------
// rsi_sqrt
// Pipelined floor square root, one root bit per stage.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rsi_sqrt
   import rsi_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  rsi_tag_type       tag_in,
   input  logic [DISC_W-1:0] disc,
   output rsi_tag_type       tag_out,
   output logic [ROOT_W-1:0] root
);

   logic [DISC_W-1:0]     rem_ff   [ROOT_W];
   logic [ROOT_W-1:0]     root_ff  [ROOT_W];
   logic                  valid_ff [ROOT_W];
   logic                  miss_ff  [ROOT_W];
   logic signed [B_W-1:0] b16_ff   [ROOT_W];

   for (genvar s = 0; s < ROOT_W; s++) begin : g_stage
      localparam int K = ROOT_W - 1 - s;
      logic [DISC_W-1:0]     rem_prev, trial;
      logic [ROOT_W-1:0]     root_prev;
      logic                  valid_prev, miss_prev;
      logic signed [B_W-1:0] b16_prev;

      if (s == 0) begin : g_first
         assign rem_prev   = disc;
         assign root_prev  = '0;
         assign valid_prev = tag_in.valid;
         assign miss_prev  = tag_in.miss;
         assign b16_prev   = tag_in.b16;
      end else begin : g_next
         assign rem_prev   = rem_ff[s-1];
         assign root_prev  = root_ff[s-1];
         assign valid_prev = valid_ff[s-1];
         assign miss_prev  = miss_ff[s-1];
         assign b16_prev   = b16_ff[s-1];
      end

      assign trial = (DISC_W'(root_prev) << (K + 1)) | (DISC_W'(1) << (2 * K));

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else begin
            valid_ff[s] <= valid_prev;
         end
      end

      always_ff @(posedge clock) begin
         miss_ff[s] <= miss_prev;
         b16_ff[s]  <= b16_prev;
         if (rem_prev >= trial) begin
            rem_ff[s]  <= rem_prev - trial;
            root_ff[s] <= root_prev | (ROOT_W'(1) << K);
         end else begin
            rem_ff[s]  <= rem_prev;
            root_ff[s] <= root_prev;
         end
      end
   end

   assign tag_out = {valid_ff[ROOT_W-1], miss_ff[ROOT_W-1], b16_ff[ROOT_W-1]};
   assign root    = root_ff[ROOT_W-1];

   // floor root leaves a remainder of at most twice the root (misses carry junk)
   `RSI_ASSERT_IMP(a_root_floor, clock, reset, valid_ff[ROOT_W-1] && !miss_ff[ROOT_W-1],
                   rem_ff[ROOT_W-1] <= DISC_W'({root_ff[ROOT_W-1], 1'b0}))

endmodule
